[src/nrmc_pkg.sv]
package nrmc_pkg;

  localparam int unsigned DIGIT_W = 20;
  localparam logic [DIGIT_W-1:0] DIGIT_MAX = 20'd999999;
  localparam logic [4:0] TERM_MAX = 5'd31;
  localparam logic [2:0] POS_MAX = 3'd7;
  localparam logic [2:0] NAME_LEN = 3'd5;

  // Term indexes that carry fields of interest.
  localparam logic [4:0] TERM_NAME = 5'd0;
  localparam logic [4:0] TERM_TIME = 5'd1;
  localparam logic [4:0] TERM_STATUS = 5'd2;
  localparam logic [4:0] TERM_DATE = 5'd9;

  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_A = 8'h41;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  typedef struct packed {
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic               sentence_ok;
    logic [DIGIT_W-1:0] utc_time;
    logic [DIGIT_W-1:0] utc_date;
  } out_item_t;

  typedef struct packed {
    logic [7:0]         running_xor;
    logic               in_payload;
    logic               is_rmc;
    logic               fix_valid;
    logic [4:0]         term_index;
    logic [2:0]         char_pos;
    logic               name_match;
    logic [DIGIT_W-1:0] digit_acc;
    logic               digits_ended;
    logic               first_is_a;
    logic [7:0]         hex_hi_char;
    logic [7:0]         hex_lo_char;
    logic [DIGIT_W-1:0] time_reg;
    logic [DIGIT_W-1:0] date_reg;
  } parse_state_t;

  // Expected character of the sentence name at a given position.
  function automatic logic [7:0] name_char(input logic [2:0] pos);
    logic [7:0] ch;
    case (pos)
      3'd0: ch = 8'h47;
      3'd1: ch = 8'h50;
      3'd2: ch = 8'h52;
      3'd3: ch = 8'h4D;
      3'd4: ch = 8'h43;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Hex digit value; bit 4 set means the character is not a hex digit.
  function automatic logic [4:0] hex_value(input logic [7:0] ch);
    logic [4:0] v;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      v = {1'b0, ch[3:0]};
    end else if ((ch >= 8'h41 && ch <= 8'h46) || (ch >= 8'h61 && ch <= 8'h66)) begin
      v = {1'b0, ch[3:0] + 4'd9};
    end else begin
      v = 5'd16;
    end
    return v;
  endfunction

endpackage

[src/nrmc_stream_if.sv]
interface nrmc_stream_if #(
  parameter type payload_t = logic [7:0]
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[src/nrmc_core.sv]
module nrmc_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  logic [7:0]         rx_byte,
  output nrmc_pkg::out_item_t result
);

  nrmc_pkg::parse_state_t st_r;
  nrmc_pkg::parse_state_t st_nxt;
  nrmc_pkg::parse_state_t st_init;
  logic                   ok;
  logic [23:0]            acc_wide;
  logic [4:0]             hi_val;
  logic [4:0]             lo_val;
  logic                   is_digit;

  assign is_digit = (rx_byte >= nrmc_pkg::CH_ZERO) && (rx_byte <= nrmc_pkg::CH_NINE);
  assign acc_wide = {4'd0, st_r.digit_acc} * 24'd10 + {20'd0, rx_byte[3:0]};
  assign hi_val = nrmc_pkg::hex_value(st_r.hex_hi_char);
  assign lo_val = nrmc_pkg::hex_value(st_r.hex_lo_char);

  // Everything clears on reset except the name match, which starts out set.
  always_comb begin
    st_init = '0;
    st_init.name_match = 1'b1;
  end

  always_comb begin
    st_nxt = st_r;
    ok = 1'b0;
    if (!rx_byte[7]) begin
      case (rx_byte)
        nrmc_pkg::CH_COMMA: begin
          st_nxt.running_xor = st_r.running_xor ^ rx_byte;
          if (st_r.term_index == nrmc_pkg::TERM_NAME && st_r.name_match &&
              st_r.char_pos == nrmc_pkg::NAME_LEN) begin
            st_nxt.is_rmc = 1'b1;
          end
          if (st_nxt.is_rmc) begin
            if (st_r.term_index == nrmc_pkg::TERM_TIME) begin
              st_nxt.time_reg = st_r.digit_acc;
            end else if (st_r.term_index == nrmc_pkg::TERM_STATUS) begin
              st_nxt.fix_valid = st_r.first_is_a;
            end else if (st_r.term_index == nrmc_pkg::TERM_DATE) begin
              st_nxt.date_reg = st_r.digit_acc;
            end
          end
          if (st_r.term_index != nrmc_pkg::TERM_MAX) begin
            st_nxt.term_index = st_r.term_index + 5'd1;
          end
          st_nxt.char_pos = '0;
          st_nxt.name_match = 1'b1;
          st_nxt.digit_acc = '0;
          st_nxt.digits_ended = 1'b0;
          st_nxt.first_is_a = 1'b0;
        end
        nrmc_pkg::CH_STAR: begin
          st_nxt.in_payload = 1'b0;
          st_nxt.char_pos = '0;
          st_nxt.name_match = 1'b0;
        end
        nrmc_pkg::CH_CR: begin
          st_nxt = st_r;
        end
        nrmc_pkg::CH_LF, nrmc_pkg::CH_DOLLAR: begin
          if (rx_byte == nrmc_pkg::CH_LF && st_r.fix_valid) begin
            ok = !hi_val[4] && !lo_val[4] && ({hi_val[3:0], lo_val[3:0]} == st_r.running_xor);
          end else begin
            st_nxt.running_xor = '0;
            st_nxt.in_payload = (rx_byte == nrmc_pkg::CH_DOLLAR);
            st_nxt.is_rmc = 1'b0;
            st_nxt.fix_valid = 1'b0;
            st_nxt.term_index = '0;
            st_nxt.hex_hi_char = '0;
            st_nxt.hex_lo_char = '0;
            st_nxt.char_pos = '0;
            st_nxt.name_match = 1'b1;
            st_nxt.digit_acc = '0;
            st_nxt.digits_ended = 1'b0;
            st_nxt.first_is_a = 1'b0;
          end
        end
        default: begin
          if (st_r.in_payload) begin
            st_nxt.running_xor = st_r.running_xor ^ rx_byte;
          end else if (st_r.char_pos == 3'd0) begin
            st_nxt.hex_hi_char = rx_byte;
          end else if (st_r.char_pos == 3'd1) begin
            st_nxt.hex_lo_char = rx_byte;
          end
          if (st_r.char_pos == 3'd0) begin
            st_nxt.first_is_a = (rx_byte == nrmc_pkg::CH_A);
          end
          if (st_r.char_pos >= nrmc_pkg::NAME_LEN ||
              rx_byte != nrmc_pkg::name_char(st_r.char_pos)) begin
            st_nxt.name_match = 1'b0;
          end
          if (!st_r.digits_ended && is_digit) begin
            st_nxt.digit_acc = (acc_wide > {4'd0, nrmc_pkg::DIGIT_MAX}) ?
                               nrmc_pkg::DIGIT_MAX : acc_wide[nrmc_pkg::DIGIT_W-1:0];
          end else begin
            st_nxt.digits_ended = 1'b1;
          end
          if (st_r.char_pos != nrmc_pkg::POS_MAX) begin
            st_nxt.char_pos = st_r.char_pos + 3'd1;
          end
        end
      endcase
    end
  end

  always_comb begin
    result.sentence_ok = ok;
    result.utc_time = st_nxt.time_reg;
    result.utc_date = st_nxt.date_reg;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= st_init;
    end else if (step) begin
      st_r <= st_nxt;
    end
  end

endmodule

[src/nmea_rmc_sentence_parser_unit.sv]
// Byte-serial parser for NMEA 0183 RMC sentences. Every accepted byte gives
// exactly one result beat: sentence_ok is high only for the newline that ends
// a GPRMC sentence with an 'A' fix status and a matching XOR checksum, and
// utc_time/utc_date always show the last time and date terms parsed. One byte
// is taken per cycle while the result side is not stalled. A byte is held in the
// input register while the parser state updates, and its result beat is loaded
// into the result register as the byte advances and is offered from there. The
// rate is set by the parser state update.
module nmea_rmc_sentence_parser_unit (
  input logic           clk,
  input logic           rst_n,
  nrmc_stream_if.sink   in_ch,
  nrmc_stream_if.source out_ch
);

  logic                in_vld_r;
  logic [7:0]          in_byte_r;
  logic                out_vld_r;
  nrmc_pkg::out_item_t out_r;
  nrmc_pkg::out_item_t core_result;
  logic                advance;

  // The held byte moves on when the result register is free or being emptied.
  assign advance = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_byte_r <= in_ch.payload.rx_byte;
    end
  end

  nrmc_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .rx_byte (in_byte_r),
    .result  (core_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= core_result;
    end
  end

  assign out_ch.valid = out_vld_r;
  assign out_ch.payload = out_r;

  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !advance |=> in_vld_r && $stable(in_byte_r))
    else $error("held input byte lost while the result side was stalled");

  a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_vld_r)
    else $error("result beat missing after a byte was processed");

  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_r.utc_time <= nrmc_pkg::DIGIT_MAX) &&
                  (out_r.utc_date <= nrmc_pkg::DIGIT_MAX))
    else $error("time or date beyond saturation limit");

endmodule

[bench/nmea_rmc_sentence_parser_unit_test.sv]
module nmea_rmc_sentence_parser_unit_test;

  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [39:0] RMC_WORD = "GPRMC";

  typedef enum {HEX_GOOD, HEX_BAD, HEX_ONE, HEX_NONE, HEX_JUNK, NO_STAR} hex_form_t;

  logic clk;
  logic rst_n;

  nrmc_stream_if #(.payload_t(nrmc_pkg::in_item_t)) in_ch ();
  nrmc_stream_if #(.payload_t(nrmc_pkg::out_item_t)) out_ch ();

  nmea_rmc_sentence_parser_unit uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source)
  );

  logic [7:0] pending_bytes[$];
  logic [7:0] sentence_body[$];
  nrmc_pkg::out_item_t parse_results[$];
  int unsigned bytes_queued;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_asked;
  int unsigned hold_granted;
  int unsigned hold_left;
  int unsigned fault_count;
  int unsigned beats_checked;
  int unsigned quiet_cycles;

  // Parser state as the bench expects it to evolve.
  logic [7:0]  chk_acc;
  logic        payload_on;
  logic        rmc_seen;
  logic        fix_ok;
  logic [4:0]  term_no;
  logic [2:0]  pos;
  logic        name_ok;
  logic [19:0] num_acc;
  logic        num_done;
  logic        lead_a;
  logic [7:0]  hex_hi;
  logic [7:0]  hex_lo;
  logic [19:0] time_val;
  logic [19:0] date_val;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
  end

  task automatic flag_mismatch(input string what);
    fault_count++;
    $display("mismatch: %s", what);
  endtask

  function automatic int nibble_of(input logic [7:0] c);
    if (c >= nrmc_pkg::CH_ZERO && c <= nrmc_pkg::CH_NINE) return c - nrmc_pkg::CH_ZERO;
    if (c >= nrmc_pkg::CH_A && c <= nrmc_pkg::CH_A + 8'd5) return c - nrmc_pkg::CH_A + 10;
    if (c >= CH_LOWER_A && c <= CH_LOWER_A + 8'd5) return c - CH_LOWER_A + 10;
    return -1;
  endfunction

  task automatic clear_term();
    pos = '0;
    name_ok = 1'b1;
    num_acc = '0;
    num_done = 1'b0;
    lead_a = 1'b0;
  endtask

  task automatic open_sentence(input logic with_payload);
    chk_acc = '0;
    payload_on = with_payload;
    rmc_seen = 1'b0;
    fix_ok = 1'b0;
    term_no = '0;
    hex_hi = '0;
    hex_lo = '0;
    clear_term();
  endtask

  task automatic close_term();
    if (term_no == nrmc_pkg::TERM_NAME && name_ok && pos == nrmc_pkg::NAME_LEN) rmc_seen = 1'b1;
    if (rmc_seen) begin
      if (term_no == nrmc_pkg::TERM_TIME) time_val = num_acc;
      else if (term_no == nrmc_pkg::TERM_STATUS) fix_ok = lead_a;
      else if (term_no == nrmc_pkg::TERM_DATE) date_val = num_acc;
    end
    if (term_no < nrmc_pkg::TERM_MAX) term_no++;
    clear_term();
  endtask

  task automatic absorb_char(input logic [7:0] c);
    int unsigned grown;
    if (payload_on) begin
      chk_acc ^= c;
    end else if (pos == 3'd0) begin
      hex_hi = c;
    end else if (pos == 3'd1) begin
      hex_lo = c;
    end
    if (pos == 3'd0) lead_a = (c == nrmc_pkg::CH_A);
    if (pos >= nrmc_pkg::NAME_LEN || c != RMC_WORD[39 - 8 * pos -: 8]) name_ok = 1'b0;
    if (!num_done && c >= nrmc_pkg::CH_ZERO && c <= nrmc_pkg::CH_NINE) begin
      grown = num_acc * 10 + (c - nrmc_pkg::CH_ZERO);
      num_acc = (grown > nrmc_pkg::DIGIT_MAX) ? nrmc_pkg::DIGIT_MAX : grown[19:0];
    end else begin
      num_done = 1'b1;
    end
    if (pos < nrmc_pkg::POS_MAX) pos++;
  endtask

  // Advances the expected parser state by one byte and gives the result beat.
  task automatic advance_parser(input logic [7:0] c, output nrmc_pkg::out_item_t res);
    int hi;
    int lo;
    logic ok;
    ok = 1'b0;
    if (!c[7]) begin
      case (c)
        nrmc_pkg::CH_COMMA: begin
          chk_acc ^= c;
          close_term();
        end
        nrmc_pkg::CH_STAR: begin
          payload_on = 1'b0;
          pos = '0;
          name_ok = 1'b0;
        end
        nrmc_pkg::CH_CR: ;
        nrmc_pkg::CH_LF: begin
          if (fix_ok) begin
            hi = nibble_of(hex_hi);
            lo = nibble_of(hex_lo);
            ok = (hi >= 0 && lo >= 0 && ((hi << 4) | lo) == chk_acc);
          end else begin
            open_sentence(1'b0);
          end
        end
        nrmc_pkg::CH_DOLLAR: open_sentence(1'b1);
        default: absorb_char(c);
      endcase
    end
    res.sentence_ok = ok;
    res.utc_time = time_val;
    res.utc_date = date_val;
  endtask

  always @(posedge clk) begin : feed_bytes
    nrmc_pkg::out_item_t res;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.payload <= '0;
      open_sentence(1'b0);
      time_val = '0;
      date_val = '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        advance_parser(pending_bytes.pop_front(), res);
        parse_results.push_back(res);
      end
      if (in_ch.valid && !in_ch.ready) begin
        // The offered beat must stay put until it is taken.
      end else if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_ch.valid <= 1'b1;
        in_ch.payload.rx_byte <= pending_bytes[0];
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : take_results
    nrmc_pkg::out_item_t want;
    nrmc_pkg::out_item_t got;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.payload;
        if (parse_results.size() == 0) begin
          flag_mismatch("result beat arrived with nothing outstanding");
        end else begin
          want = parse_results.pop_front();
          if (got.sentence_ok !== want.sentence_ok)
            flag_mismatch($sformatf("beat %0d sentence_ok %b, expected %b",
                                    beats_checked, got.sentence_ok, want.sentence_ok));
          if (got.utc_time !== want.utc_time)
            flag_mismatch($sformatf("beat %0d utc_time %0d, expected %0d",
                                    beats_checked, got.utc_time, want.utc_time));
          if (got.utc_date !== want.utc_date)
            flag_mismatch($sformatf("beat %0d utc_date %0d, expected %0d",
                                    beats_checked, got.utc_date, want.utc_date));
        end
        beats_checked++;
      end
      if (hold_granted != hold_asked) begin
        hold_granted = hold_asked;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles = 0;
      end else if (pending_bytes.size() != 0 || parse_results.size() != 0) begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic push_byte(input logic [7:0] b);
    pending_bytes.push_back(b);
    bytes_queued++;
  endtask

  task automatic body_text(input string s);
    for (int i = 0; i < s.len(); i++) sentence_body.push_back(s[i]);
  endtask

  task automatic body_digits(input int n);
    repeat (n) sentence_body.push_back(nrmc_pkg::CH_ZERO + 8'($urandom_range(9)));
  endtask

  task automatic body_filler(input int n);
    string pool;
    pool = "0123456789.NSEWAV";
    repeat (n) sentence_body.push_back(pool[$urandom_range(pool.len() - 1)]);
  endtask

  // Mostly up to six digits; now and then long enough to saturate.
  task automatic body_number();
    int n;
    n = ($urandom_range(7) == 0) ? $urandom_range(7, 10) : $urandom_range(0, 6);
    body_digits(n);
    if ($urandom_range(1) == 1) begin
      body_text(".");
      body_digits($urandom_range(1, 3));
    end
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
    if (n < 4'd10) return nrmc_pkg::CH_ZERO + n;
    return (lower ? CH_LOWER_A : nrmc_pkg::CH_A) + n - 8'd10;
  endfunction

  // Frames the collected body with '$', the checksum field and the line end.
  task automatic emit_sentence(input hex_form_t form, input bit corrupt);
    logic [7:0] sum;
    bit lower;
    string junk;
    sum = '0;
    lower = 1'($urandom_range(1));
    junk = "GgZz./";
    foreach (sentence_body[i]) sum ^= sentence_body[i];
    if (form == HEX_BAD) sum ^= 8'($urandom_range(1, 255));
    if (corrupt) sentence_body[$urandom_range(sentence_body.size() - 1)] = 8'($urandom_range(255));
    push_byte(nrmc_pkg::CH_DOLLAR);
    foreach (sentence_body[i]) push_byte(sentence_body[i]);
    if (form != NO_STAR) push_byte(nrmc_pkg::CH_STAR);
    case (form)
      HEX_GOOD, HEX_BAD: begin
        push_byte(hex_char(sum[7:4], lower));
        push_byte(hex_char(sum[3:0], lower));
      end
      HEX_ONE: push_byte(hex_char(sum[7:4], lower));
      HEX_JUNK: begin
        push_byte(junk[$urandom_range(junk.len() - 1)]);
        push_byte(hex_char(sum[3:0], lower));
      end
      default: ;
    endcase
    if ($urandom_range(3) != 0) push_byte(nrmc_pkg::CH_CR);
    push_byte(nrmc_pkg::CH_LF);
  endtask

  task automatic queue_rmc();
    int pick;
    hex_form_t form;
    sentence_body.delete();
    pick = $urandom_range(99);
    if (pick < 85) body_text("GPRMC");
    else if (pick < 90) body_text("GNRMC");
    else if (pick < 94) body_text("GPRMCA");
    else if (pick < 97) body_text("GPRM");
    else body_text("GPGGA");
    body_text(",");
    body_number();
    body_text(",");
    pick = $urandom_range(99);
    if (pick < 70) body_text("A");
    else if (pick < 85) body_text("V");
    else if (pick < 95) body_text("AV");
    else if (pick < 98) body_filler(1);
    body_filler(0);
    repeat (6) begin
      body_text(",");
      body_filler($urandom_range(0, 5));
    end
    body_text(",");
    body_number();
    if ($urandom_range(19) == 0) begin
      repeat ($urandom_range(20, 30)) begin
        body_text(",");
        body_filler($urandom_range(0, 2));
      end
    end else begin
      repeat (2) begin
        body_text(",");
        body_filler($urandom_range(0, 1));
      end
    end
    pick = $urandom_range(99);
    if (pick < 78) form = HEX_GOOD;
    else if (pick < 86) form = HEX_BAD;
    else if (pick < 90) form = HEX_ONE;
    else if (pick < 93) form = HEX_NONE;
    else if (pick < 96) form = HEX_JUNK;
    else form = NO_STAR;
    emit_sentence(form, $urandom_range(9) == 0);
  endtask

  task automatic queue_noise();
    repeat ($urandom_range(1, 8)) begin
      if ($urandom_range(2) == 0) begin
        case ($urandom_range(5))
          0: push_byte(nrmc_pkg::CH_COMMA);
          1: push_byte(nrmc_pkg::CH_STAR);
          2: push_byte(nrmc_pkg::CH_DOLLAR);
          3: push_byte(nrmc_pkg::CH_CR);
          4: push_byte(nrmc_pkg::CH_LF);
          default: push_byte(nrmc_pkg::CH_A);
        endcase
      end else begin
        push_byte(8'($urandom_range(255)));
      end
    end
  endtask

  task automatic fill_to(input int unsigned target);
    while (bytes_queued < target) begin
      if ($urandom_range(99) < 85) queue_rmc();
      else queue_noise();
    end
  endtask

  task automatic wait_drained();
    while (pending_bytes.size() != 0 || parse_results.size() != 0) @(negedge clk);
  endtask

  initial begin
    bytes_queued = 0;
    send_idle_pct = 12;
    recv_idle_pct = 66;
    hold_asked = 0;
    hold_granted = 0;
    hold_left = 0;
    fault_count = 0;
    beats_checked = 0;
    quiet_cycles = 0;
    @(posedge rst_n);
    @(negedge clk);

    // Extreme byte values, then the shortest sentence that carries a date.
    push_byte(8'h00);
    push_byte(8'h7F);
    push_byte(8'h80);
    push_byte(8'hFF);
    sentence_body.delete();
    body_text("GPRMC,1,A,,,,,,,9");
    emit_sentence(HEX_GOOD, 1'b0);
    fill_to(600);
    wait_drained();

    send_idle_pct = 66;
    recv_idle_pct = 12;
    fill_to(1200);
    wait_drained();

    // No idling; a long receiver hold-off backs the block up first.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_asked++;
    fill_to(1750);
    wait_drained();

    repeat (8) @(negedge clk);
    if (fault_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
